[rtl/ecc_pkg.sv]
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the elevator car controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

    localparam int DEF_FLOORS   = 32;
    localparam int DEF_CAPACITY = 8;
    localparam int FLOOR_W      = 5;
    localparam int CNT_W        = 4;
    localparam int TICK_W       = 8;

    localparam logic [1:0] M_STOPPED  = 2'd0;
    localparam logic [1:0] M_UP       = 2'd1;
    localparam logic [1:0] M_DOWN     = 2'd2;
    localparam logic [1:0] M_STOPPING = 2'd3;

    localparam logic [1:0] K_TICK   = 2'd0;
    localparam logic [1:0] K_BOARD  = 2'd1;
    localparam logic [1:0] K_UNLOAD = 2'd2;
    localparam logic [1:0] K_SUMMON = 2'd3;

    localparam logic [TICK_W-1:0] STOP_TICKS = 8'd2;

    localparam logic [0:0] REG_FLOOR_COUNT = 1'd0;
    localparam logic [0:0] REG_TICKS       = 1'd1;

    // controller -> datapath
    typedef struct packed {
        logic start;      // latch item, run the non-scan part
        logic scan_clr;   // reset compaction indexes
        logic scan_step;  // examine one rider entry
        logic scan_done;  // commit compacted count
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_unload;  // latched item is an unload while stopped
        logic scan_last;  // current scan index is the last entry
    } t_dp_sts;

endpackage

[rtl/ecc_ctrl.sv]
// ----------------------------------------------------------------------------
// ecc_ctrl
// Sequencer: accept one transaction, run the unload scan for an unload, present result.
// ----------------------------------------------------------------------------
module ecc_ctrl
    import ecc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);
    typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_SCAN, S_OUT} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_unload) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    n_out_valid = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    o_cmd.scan_done = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

[rtl/ecc_dp.sv]
// ----------------------------------------------------------------------------
// ecc_dp
// Car state, target and summon maps, rider destination store and result.
// ----------------------------------------------------------------------------
module ecc_dp
    import ecc_pkg::*;
#(
    parameter int FLOORS   = DEF_FLOORS,
    parameter int CAPACITY = DEF_CAPACITY
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_kind,
    input  logic [FLOOR_W-1:0]  i_floor,
    input  logic                i_flag,
    input  logic [5:0]          i_floor_count,
    input  logic [TICK_W-1:0]   i_ticks_per_floor,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic [23:0]         o_result
);
    localparam int MAP_W = (FLOORS < 32) ? FLOORS : 32;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RC_W  = $clog2(CAPACITY + 1);
    localparam logic [5:0] TOP = 6'(MAP_W);

    logic [1:0]         r_motion;
    logic [TICK_W-1:0]  r_elapsed, r_goal;
    logic [FLOOR_W-1:0] r_cur;
    logic               r_last_up;
    logic [31:0]        r_up_t, r_dn_t, r_summon;
    logic [RC_W-1:0]    r_count, r_k, r_i;
    logic [FLOOR_W-1:0] r_dest [CAPACITY];
    logic               r_unl_go, r_acc;
    logic [CNT_W-1:0]   r_unl;

    // effective floor count
    logic [5:0] n_eff;
    always_comb begin
        n_eff = i_floor_count;
        if (n_eff < 6'd2) n_eff = 6'd2;
        if (n_eff > TOP)  n_eff = TOP;
    end

    logic [31:0] valid_mask, s_eff, above, below, s_up, s_dn;
    assign valid_mask = (n_eff >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n_eff) - 32'd1);
    assign s_eff = r_summon & valid_mask;
    assign above = ~((32'd2 << r_cur) - 32'd1);
    assign below = (32'd1 << r_cur) - 32'd1;
    assign s_up  = s_eff & above;
    assign s_dn  = s_eff & below;

    // nearest summon distances
    logic [5:0] du, dd;
    always_comb begin
        du = 6'd63;
        for (int f = 31; f >= 0; f--)
            if (s_up[f]) du = 6'(f) - {1'b0, r_cur};
        dd = 6'd63;
        for (int f = 0; f < 32; f++)
            if (s_dn[f]) dd = {1'b0, r_cur} - 6'(f);
    end

    logic [1:0] choice;
    always_comb begin
        logic [1:0] pref;
        pref = r_last_up ? M_UP : M_DOWN;
        if (r_up_t != 0 && r_dn_t != 0) choice = pref;
        else if (r_up_t != 0)           choice = M_UP;
        else if (r_dn_t != 0)           choice = M_DOWN;
        else if (s_up != 0 && s_dn != 0)
            choice = (du < dd) ? M_UP : (du > dd) ? M_DOWN : pref;
        else if (s_up != 0)             choice = M_UP;
        else if (s_dn != 0)             choice = M_DOWN;
        else                            choice = M_STOPPED;
    end

    // tick next state
    logic [1:0]         t_mot;
    logic [FLOOR_W-1:0] t_cur;
    always_comb begin
        logic [FLOOR_W-1:0] nf;
        logic [31:0] sa, sb;
        t_mot = r_motion;
        t_cur = r_cur;
        nf    = r_cur;
        sa = s_eff & ~((32'd4 << r_cur) - 32'd1);
        sb = s_eff & ((32'd1 << r_cur) - 32'd1) & ~(32'd1 << (r_cur - 5'd1));
        unique case (r_motion)
            M_STOPPED: t_mot = choice;
            M_UP: begin
                if ({1'b0, r_cur} + 6'd1 >= n_eff) t_mot = M_STOPPING;
                else begin
                    nf    = r_cur + 5'd1;
                    t_cur = nf;
                    if (r_up_t[nf] || s_eff[nf] || (r_up_t == 0 && sa == 0))
                        t_mot = M_STOPPING;
                end
            end
            M_DOWN: begin
                if (r_cur == '0) t_mot = M_STOPPING;
                else begin
                    nf    = r_cur - 5'd1;
                    t_cur = nf;
                    if (r_dn_t[nf] || s_eff[nf] || (r_dn_t == 0 && sb == 0))
                        t_mot = M_STOPPING;
                end
            end
            default: t_mot = M_STOPPED;
        endcase
    end

    logic [RC_W-1:0] cap_c;
    assign cap_c = RC_W'(CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion  <= M_STOPPED;
            r_elapsed <= '0;
            r_goal    <= '0;
            r_cur     <= '0;
            r_last_up <= 1'b0;
            r_up_t    <= '0;
            r_dn_t    <= '0;
            r_summon  <= '0;
            r_count   <= '0;
            r_unl_go  <= 1'b0;
            r_acc     <= 1'b0;
            r_unl     <= '0;
            r_k       <= '0;
            r_i       <= '0;
        end else begin
            if (i_cmd.start) begin
                r_acc    <= 1'b0;
                r_unl    <= '0;
                r_unl_go <= 1'b0;
                case (i_kind)
                    K_TICK: begin
                        if (r_elapsed != r_goal) r_elapsed <= r_elapsed + 8'd1;
                        else begin
                            r_motion  <= t_mot;
                            r_cur     <= t_cur;
                            r_elapsed <= '0;
                            unique case (t_mot)
                                M_STOPPED: r_goal <= '0;
                                M_UP: begin
                                    r_goal <= i_ticks_per_floor; r_last_up <= 1'b1;
                                end
                                M_DOWN: begin
                                    r_goal <= i_ticks_per_floor; r_last_up <= 1'b0;
                                end
                                default: r_goal <= STOP_TICKS;
                            endcase
                        end
                    end
                    K_BOARD: begin
                        if (r_count < cap_c && {1'b0, i_floor} < n_eff) begin
                            r_dest[r_count[IDX_W-1:0]] <= i_floor;
                            r_count <= r_count + 1'b1;
                            if (i_floor > r_cur) r_up_t[i_floor] <= 1'b1;
                            else                 r_dn_t[i_floor] <= 1'b1;
                            r_acc <= 1'b1;
                        end
                    end
                    K_UNLOAD: begin
                        if (r_motion == M_STOPPED) begin
                            r_up_t[r_cur] <= 1'b0;
                            r_dn_t[r_cur] <= 1'b0;
                            r_acc    <= 1'b1;
                            r_unl_go <= 1'b1;
                        end
                    end
                    default: begin
                        if ({1'b0, i_floor} < n_eff) begin
                            r_summon[i_floor] <= i_flag;
                            r_acc <= 1'b1;
                        end
                    end
                endcase
            end
            if (i_cmd.scan_clr) begin
                r_k <= '0;
                r_i <= '0;
            end
            if (i_cmd.scan_step && r_i < r_count) begin
                if (r_dest[r_i[IDX_W-1:0]] == r_cur) r_unl <= r_unl + 1'b1;
                else begin
                    r_dest[r_k[IDX_W-1:0]] <= r_dest[r_i[IDX_W-1:0]];
                    r_k <= r_k + 1'b1;
                end
            end
            if (i_cmd.scan_step) r_i <= r_i + 1'b1;
            if (i_cmd.scan_done) begin
                if (r_i < r_count && r_dest[r_i[IDX_W-1:0]] != r_cur) r_count <= r_k + 1'b1;
                else if (r_i < r_count) r_count <= r_k;
                else r_count <= r_k;
            end
        end
    end

    assign o_sts.is_unload = r_unl_go;
    assign o_sts.scan_last = (r_i >= r_count) || (r_i == RC_W'(CAPACITY - 1));

    logic full;
    assign full = (r_count >= cap_c);
    assign o_result = {7'd0, r_unl, r_acc, full, CNT_W'(r_count), r_cur, r_motion};
endmodule

[rtl/elevator_car_controller.sv]
// ----------------------------------------------------------------------------
// elevator_car_controller
// One elevator car: motion, timer, targets, summons and riders on board.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream (s_axis): one transaction per event - tick, board a rider,
//  unload at the current floor, or set/clear a hall summon.
//  Output stream (m_axis): exactly one result transaction per input, giving
//  motion, car floor, rider count, full flag, accepted flag and the number
//  of riders unloaded.
//  Configuration (APB): floor_count at 0x0, ticks_per_floor at 0x4. Write
//  only while idle.
//  Sequence: tick, board and summon go through a decide state before
//  m_axis_tvalid rises; unload then walks the rider store one entry a
//  cycle in a scan state before the result is raised. One item is in
//  flight at a time: a new transaction is taken only after the result
//  has been accepted. The rider scan makes an unload with a full car the
//  longest transaction.
//  Reset clears motion, timer, floor, maps and rider count; registers go
//  to 32 floors and 3 ticks per floor.
//  A stalled receiver holds the result and s_axis_tready stays low.
// ----------------------------------------------------------------------------
module elevator_car_controller
    import ecc_pkg::*;
#(
    parameter int FLOORS   = DEF_FLOORS,
    parameter int CAPACITY = DEF_CAPACITY
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [4:0] floor, [5] summon_flag
    input  logic [1:0]  s_axis_tuser,  // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] motion, [6:2] car_floor, [10:7] rider_total, [11] full_res,
    // [12] accepted, [16:13] unloaded_count
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [5:0]        r_floor_count;
    logic [TICK_W-1:0] r_ticks;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_count <= 6'd32;
            r_ticks       <= 8'd3;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_FLOOR_COUNT) r_floor_count <= pwdata[5:0];
            else                             r_ticks       <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_FLOOR_COUNT) prdata = {26'd0, r_floor_count};
            else                             prdata = {24'd0, r_ticks};
        end
    end

    ecc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    ecc_dp #(.FLOORS(FLOORS), .CAPACITY(CAPACITY)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_kind            (s_axis_tuser),
        .i_floor           (s_axis_tdata[4:0]),
        .i_flag            (s_axis_tdata[5]),
        .i_floor_count     (r_floor_count),
        .i_ticks_per_floor (r_ticks),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_result          (m_axis_tdata)
    );
endmodule

[rtl/ecc_checker.sv]
// ----------------------------------------------------------------------------
// ecc_checker
// Port-level checks for the elevator car controller.
// ----------------------------------------------------------------------------
module ecc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // no new input while a result is pending
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");

    // held result stays stable
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // unloaded riders imply accepted
    a_unl_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[16:13] != 4'd0 |-> m_axis_tdata[12])
        else $error("unload count without accept");

    // accept leads to no output in the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind elevator_car_controller ecc_checker u_ecc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
